// File: sv/swem_pkg.sv
// Shared types and constants of the spoken word endpoint matcher.
package swem_pkg;

  localparam int COEFFS = 8;
  localparam int COEF_W = 8;
  localparam int SIL_MAX = 255;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_VALUE = 2'd1;
  localparam logic [1:0] OP_LABEL = 2'd2;

  localparam logic [2:0] REG_ON_THR   = 3'd0;
  localparam logic [2:0] REG_OFF_THR  = 3'd1;
  localparam logic [2:0] REG_MIN_FRM  = 3'd2;
  localparam logic [2:0] REG_END_SIL  = 3'd3;
  localparam logic [2:0] REG_DISC_SIL = 3'd4;
  localparam logic [2:0] REG_ENTRIES  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEARCH,
    ST_DRAIN
  } state_t;

endpackage

// File: sv/spoken_word_endpoint_matcher_unit.sv
// Top level of the spoken word endpoint matcher: word capture and codebook search.
//
// Items enter on the s_axis channel: a feature frame, a codebook value write or a
// codebook label write, selected by the operation field on s_axis_tuser. Every item
// yields exactly one result item on m_axis; match_valid travels on m_axis_tuser and is
// set only when a frame completed a word and at least one codebook entry is in use.
// Registers are written on the cfg channel, which is always ready; the user must write them
// only while the block is idle, which the block itself does not enforce. A codebook write or
// a frame that does not complete a word gives its result in the cycle after acceptance.
// A frame that completes a word with at least one codebook entry in use starts a search:
// the resampling step is first set up by repeated subtraction, then one codebook value is
// read per cycle through all entries in use, then the distance pipeline drains. The book
// value memory with one read port sets that rate. s_axis_tready is low during a search.
// Reset clears the counters, the registers to their defaults and the output stage;
// the word store and codebook memories are not cleared and hold garbage until written.
// When the receiver stalls the result is held in the output register and no new item
// is taken until it leaves.
module spoken_word_endpoint_matcher_unit #(
  parameter int MAX_FRAMES  = 32,
  parameter int WARP_FRAMES = 16,
  parameter int ENTRIES     = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  // energy[15:0], coef0..coef7[79:16], book_addr[92:80], book_data[101:93],
  // zero pad[103:102]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // match_valid[0]
  output logic         m_axis_tuser,
  // match_label[7:0], match_distance[31:8]
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int ES         = WARP_FRAMES * swem_pkg::COEFFS;
  localparam int BOOK_DEPTH = ENTRIES * ES;
  localparam int BAW        = $clog2(BOOK_DEPTH);
  localparam int WAW        = $clog2(MAX_FRAMES);
  localparam int LAW        = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int FCW        = $clog2(MAX_FRAMES + 1);
  localparam int IW         = $clog2(WARP_FRAMES);
  localparam int EW         = $clog2(ENTRIES + 1);
  localparam int NW         = $clog2(swem_pkg::COEFFS);
  localparam int ROW_W      = swem_pkg::COEFFS * swem_pkg::COEF_W;

  // input fields
  logic [1:0]       in_op;
  logic [15:0]      in_energy;
  logic [ROW_W-1:0] in_row;
  logic [12:0]      in_addr;
  logic [8:0]       in_data;

  assign in_op     = s_axis_tuser;
  assign in_energy = s_axis_tdata[15:0];
  assign in_row    = s_axis_tdata[79:16];
  assign in_addr   = s_axis_tdata[92:80];
  assign in_data   = s_axis_tdata[101:93];

  // configuration registers
  logic [15:0] on_threshold, off_threshold;
  logic [5:0]  min_frames;
  logic [7:0]  end_silence, discard_silence;
  logic [6:0]  entry_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold    <= 16'd600;
      off_threshold   <= 16'd500;
      min_frames      <= 6'd8;
      end_silence     <= 8'd15;
      discard_silence <= 8'd20;
      entry_count     <= 7'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        swem_pkg::REG_ON_THR:   on_threshold    <= cfg_data;
        swem_pkg::REG_OFF_THR:  off_threshold   <= cfg_data;
        swem_pkg::REG_MIN_FRM:  min_frames      <= cfg_data[5:0];
        swem_pkg::REG_END_SIL:  end_silence     <= cfg_data[7:0];
        swem_pkg::REG_DISC_SIL: discard_silence <= cfg_data[7:0];
        swem_pkg::REG_ENTRIES:  entry_count     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] entries_used;
  logic [5:0]    min_eff;
  assign entries_used = (32'(entry_count) > ENTRIES) ? EW'(ENTRIES) : EW'(entry_count);
  assign min_eff      = (min_frames == 6'd0) ? 6'd1 : min_frames;

  // state and search registers
  swem_pkg::state_t state, state_next;
  logic [FCW-1:0] frame_count;
  logic [7:0]     silence_count;
  logic [FCW-1:0] fr, fq;
  logic [IW-1:0]  ii, rr;
  logic [NW-1:0]  nn;
  logic [EW-1:0]  ee;
  logic [FCW-1:0] qq;
  logic [BAW-1:0] baddr;

  logic                    p1_valid, p1_last, p1_first;
  logic [NW-1:0]           p1_n;
  logic                    p2_valid, p2_last, p2_first;
  logic [16:0]             p2_sq;
  logic [7:0]              p2_label;
  logic [23:0]             acc, best_dist;
  logic [7:0]              best_label;
  logic                    found;

  logic        out_valid, out_mv;
  logic [7:0]  out_label;
  logic [23:0] out_dist;

  // memories
  logic             word_we;
  logic [ROW_W-1:0] word_rdata;
  logic             book_we;
  logic [7:0]       book_rdata;
  logic             label_we;
  logic [7:0]       label_rdata;

  swem_ram #(.WIDTH(ROW_W), .DEPTH(MAX_FRAMES)) u_word (
    .clk   (clk),
    .we    (word_we),
    .waddr (WAW'(frame_count)),
    .wdata (in_row),
    .raddr (WAW'(qq)),
    .rdata (word_rdata)
  );

  swem_ram #(.WIDTH(8), .DEPTH(BOOK_DEPTH)) u_book (
    .clk   (clk),
    .we    (book_we),
    .waddr (BAW'(in_addr)),
    .wdata (in_data[7:0]),
    .raddr (baddr),
    .rdata (book_rdata)
  );

  swem_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_label (
    .clk   (clk),
    .we    (label_we),
    .waddr (LAW'(in_addr)),
    .wdata (in_data[7:0]),
    .raddr (LAW'(ee)),
    .rdata (label_rdata)
  );

  // frame bookkeeping
  logic           in_acc, out_free;
  logic           cap, trig, drop;
  logic [FCW-1:0] fc1, fc2;
  logic [7:0]     sc1, sc2;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == swem_pkg::ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cap  = (in_energy > on_threshold) && (32'(frame_count) < MAX_FRAMES);
    fc1  = cap ? frame_count + FCW'(1) : frame_count;
    sc1  = cap ? 8'd0 : silence_count;
    sc2  = ((in_energy < off_threshold) && (32'(sc1) < swem_pkg::SIL_MAX)) ?
           sc1 + 8'd1 : sc1;
    fc2  = fc1;
    drop = (sc2 >= discard_silence) && (32'(fc1) < 32'(min_eff));
    if (drop) begin
      sc2 = 8'd0;
      fc2 = '0;
    end
    trig = (32'(fc2) >= MAX_FRAMES) ||
           ((sc2 >= end_silence) && (32'(fc2) >= 32'(min_eff)));
  end

  assign word_we  = in_acc && (in_op == swem_pkg::OP_FRAME) && cap;
  assign book_we  = in_acc && (in_op == swem_pkg::OP_VALUE) && (32'(in_addr) < BOOK_DEPTH);
  assign label_we = in_acc && (in_op == swem_pkg::OP_LABEL) && (32'(in_addr) < ENTRIES);

  logic start_search, issue_end, drained;
  assign start_search = in_acc && (in_op == swem_pkg::OP_FRAME) && trig &&
                        (entries_used != '0);
  assign issue_end    = (32'(ii) == WARP_FRAMES - 1) &&
                        (32'(nn) == swem_pkg::COEFFS - 1) && (ee + EW'(1) == entries_used);
  assign drained      = !p1_valid && !p2_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swem_pkg::ST_IDLE:   if (start_search) state_next = swem_pkg::ST_PREP;
      swem_pkg::ST_PREP:   if (32'(fr) < WARP_FRAMES) state_next = swem_pkg::ST_SEARCH;
      swem_pkg::ST_SEARCH: if (issue_end) state_next = swem_pkg::ST_DRAIN;
      swem_pkg::ST_DRAIN:  if (drained) state_next = swem_pkg::ST_IDLE;
      default:             state_next = swem_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      silence_count <= 8'd0;
    end else if (in_acc && (in_op == swem_pkg::OP_FRAME)) begin
      frame_count   <= trig ? '0 : fc2;
      silence_count <= trig ? 8'd0 : sc2;
    end
  end

  // resampling step: fr = len mod WARP_FRAMES, fq = len / WARP_FRAMES
  always_ff @(posedge clk) begin
    if (state == swem_pkg::ST_IDLE) begin
      fr <= fc2;
      fq <= '0;
    end else if ((state == swem_pkg::ST_PREP) && (32'(fr) >= WARP_FRAMES)) begin
      fr <= fr - FCW'(WARP_FRAMES);
      fq <= fq + FCW'(1);
    end
  end

  // issue stage: walk entry, warp frame and coefficient
  logic [IW:0] r_sum;
  assign r_sum = {1'b0, rr} + {1'b0, IW'(fr)};

  always_ff @(posedge clk) begin
    if (state != swem_pkg::ST_SEARCH) begin
      ii    <= '0;
      nn    <= '0;
      ee    <= '0;
      qq    <= '0;
      rr    <= '0;
      baddr <= '0;
    end else begin
      baddr <= baddr + BAW'(1);
      if (32'(nn) == swem_pkg::COEFFS - 1) begin
        nn <= '0;
        if (32'(ii) == WARP_FRAMES - 1) begin
          ii <= '0;
          qq <= '0;
          rr <= '0;
          ee <= ee + EW'(1);
        end else begin
          ii <= ii + IW'(1);
          if (32'(r_sum) >= WARP_FRAMES) begin
            rr <= IW'(r_sum - (IW + 1)'(WARP_FRAMES));
            qq <= qq + fq + FCW'(1);
          end else begin
            rr <= IW'(r_sum);
            qq <= qq + fq;
          end
        end
      end else begin
        nn <= nn + NW'(1);
      end
    end
  end

  // memory data stage: difference and square
  logic signed [8:0]  diff;
  logic signed [17:0] sq;
  logic [7:0]         wsel;
  assign wsel = word_rdata[p1_n * swem_pkg::COEF_W +: swem_pkg::COEF_W];
  assign diff = $signed({wsel[7], wsel}) - $signed({book_rdata[7], book_rdata});
  assign sq   = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= (state == swem_pkg::ST_SEARCH);
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_n     <= nn;
    p1_first <= (ii == '0) && (nn == '0);
    p1_last  <= (32'(ii) == WARP_FRAMES - 1) && (32'(nn) == swem_pkg::COEFFS - 1);
    p2_sq    <= sq[16:0];
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_label <= label_rdata;
  end

  // accumulate and keep the nearest entry
  logic [23:0] cand_dist;
  assign cand_dist = (p2_first ? 24'd0 : acc) + 24'(p2_sq);

  always_ff @(posedge clk) begin
    if (state == swem_pkg::ST_PREP) begin
      found <= 1'b0;
    end else if (p2_valid) begin
      acc <= cand_dist;
      if (p2_last && (!found || (cand_dist < best_dist))) begin
        best_dist  <= cand_dist;
        best_label <= p2_label;
        found      <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && !start_search) begin
      out_valid <= 1'b1;
    end else if ((state == swem_pkg::ST_DRAIN) && drained) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !start_search) begin
      out_mv    <= 1'b0;
      out_label <= 8'd0;
      out_dist  <= 24'd0;
    end else if ((state == swem_pkg::ST_DRAIN) && drained) begin
      out_mv    <= found;
      out_label <= found ? best_label : 8'd0;
      out_dist  <= found ? best_dist : 24'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_mv;
  assign m_axis_tdata  = {out_dist, out_label};

  ap_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(frame_count) <= MAX_FRAMES)
    else $error("frame count above store size");

  ap_pipe_in_search: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> (state == swem_pkg::ST_SEARCH || state == swem_pkg::ST_DRAIN))
    else $error("distance pipeline busy outside a search");

  ap_start: assert property (@(posedge clk) disable iff (rst)
    start_search |=> (state == swem_pkg::ST_PREP && frame_count == '0))
    else $error("search did not start after a completed word");

  ap_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_mv) |-> (out_label == 8'd0 && out_dist == 24'd0))
    else $error("result without match carries nonzero fields");

endmodule

// File: sv/swem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module swem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
